/* hw/rtl/tgc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tgc_pkg;

  // Screen defaults
  localparam int SCREEN_WIDTH_DEF  = 320;
  localparam int SCREEN_HEIGHT_DEF = 240;

  // Field widths
  localparam int CNT_IN_W = 4;
  localparam int RAW_W    = 12;
  localparam int TIME_W   = 32;
  localparam int CAL_W    = 16;
  localparam int COORD_W  = 9;
  localparam int GEST_W   = 3;
  localparam int THR_W    = 8;
  localparam int LP_W     = 16;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 16;

  // Mapping datapath widths
  localparam int DIFF_W = CAL_W + 2;      // raw minus signed calibration point
  localparam int SPAN_W = CAL_W + 1;      // signed calibration span
  localparam int DEN_W  = CAL_W;          // span magnitude
  localparam int NUM_W  = CAL_W + COORD_W; // product magnitude, also quotient width

  // Motion glitch limit in pixels
  localparam int GLITCH_PX = 100;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_SWAP_AXES   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_X_LEFT      = 3'd1;
  localparam logic [CFG_AW-1:0] REG_X_RIGHT     = 3'd2;
  localparam logic [CFG_AW-1:0] REG_Y_TOP       = 3'd3;
  localparam logic [CFG_AW-1:0] REG_Y_BOTTOM    = 3'd4;
  localparam logic [CFG_AW-1:0] REG_RAW_TAP     = 3'd5;
  localparam logic [CFG_AW-1:0] REG_DRAG_THR    = 3'd6;
  localparam logic [CFG_AW-1:0] REG_LONG_PRESS  = 3'd7;

  // Register reset values
  localparam logic [CAL_W-1:0] RAW_FAR_RST = 16'd4095;
  localparam logic [THR_W-1:0] DRAG_THR_RST = 8'd44;
  localparam logic [LP_W-1:0]  LONG_PRESS_RST = 16'd500;

  // Gesture codes
  localparam logic [GEST_W-1:0] GEST_NONE       = 3'd0;
  localparam logic [GEST_W-1:0] GEST_TAP        = 3'd1;
  localparam logic [GEST_W-1:0] GEST_DRAG_UP    = 3'd2;
  localparam logic [GEST_W-1:0] GEST_DRAG_DOWN  = 3'd3;
  localparam logic [GEST_W-1:0] GEST_LONG_PRESS = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the accepted request
    logic load;     // multiply and load the dividers
    logic step;     // one division step
    logic commit;   // update touch state and load the result register
  } cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/tgc_axis.sv */
`timescale 1ns / 1ps
`default_nettype none

module tgc_axis #(
  parameter int SIZE = tgc_pkg::SCREEN_WIDTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 load,
  input  wire                                 step,
  input  wire        [tgc_pkg::RAW_W-1:0]     raw,
  input  wire signed [tgc_pkg::CAL_W-1:0]     r0,
  input  wire signed [tgc_pkg::CAL_W-1:0]     r1,
  output logic       [tgc_pkg::COORD_W-1:0]   coord
);

  localparam int NUM_W = tgc_pkg::NUM_W;
  localparam int DEN_W = tgc_pkg::DEN_W;
  localparam logic [tgc_pkg::COORD_W-1:0] SIZE_M1 = tgc_pkg::COORD_W'(SIZE - 1);
  localparam logic [NUM_W-1:0] SIZE_Q = NUM_W'(SIZE);

  logic signed [tgc_pkg::DIFF_W-1:0] diff;
  logic signed [tgc_pkg::SPAN_W-1:0] span;
  logic signed [tgc_pkg::SPAN_W-1:0] span_fix;
  logic        [tgc_pkg::DIFF_W-1:0] diff_abs;
  logic        [tgc_pkg::SPAN_W-1:0] span_abs;
  logic        [NUM_W-1:0]           prod;

  logic             neg_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W:0]   rem_sh;

  // Operand prep: signed offset and span, magnitudes, one multiply
  always_comb begin
    diff = $signed({{(tgc_pkg::DIFF_W - tgc_pkg::RAW_W){1'b0}}, raw})
           - tgc_pkg::DIFF_W'(r0);
    span = tgc_pkg::SPAN_W'(r1) - tgc_pkg::SPAN_W'(r0);
    span_fix = (span == '0) ? tgc_pkg::SPAN_W'(1) : span;
    diff_abs = diff[tgc_pkg::DIFF_W-1] ? tgc_pkg::DIFF_W'(-diff) : diff;
    span_abs = span_fix[tgc_pkg::SPAN_W-1] ? tgc_pkg::SPAN_W'(-span_fix) : span_fix;
    prod = NUM_W'(diff_abs[DEN_W-1:0]) * NUM_W'(SIZE_M1);
  end

  // Restoring division step
  always_comb begin
    rem_sh = {rem_r, quo_r[NUM_W-1]};
    if (rem_sh >= {1'b0, den_r}) begin
      rem_nxt = DEN_W'(rem_sh - {1'b0, den_r});
      quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      neg_r <= diff[tgc_pkg::DIFF_W-1] ^ span_fix[tgc_pkg::SPAN_W-1];
      den_r <= span_abs[DEN_W-1:0];
      rem_r <= '0;
      quo_r <= prod;
    end else if (step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  // Clamp: a negative quotient goes to zero, an overflow to the last pixel
  always_comb begin
    if (neg_r) begin
      coord = '0;
    end else if (quo_r >= SIZE_Q) begin
      coord = SIZE_M1;
    end else begin
      coord = quo_r[tgc_pkg::COORD_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tgc_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module tgc_datapath #(
  parameter int SCREEN_WIDTH  = tgc_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = tgc_pkg::SCREEN_HEIGHT_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire  tgc_pkg::cmd_t                cmd,
  input  wire                                cfg_wr_en,
  input  wire  [tgc_pkg::CFG_AW-1:0]         cfg_addr,
  input  wire  [tgc_pkg::CFG_DW-1:0]         cfg_wdata,
  input  wire  [tgc_pkg::CNT_IN_W-1:0]       in_point_count,
  input  wire  [tgc_pkg::RAW_W-1:0]          in_raw_x,
  input  wire  [tgc_pkg::RAW_W-1:0]          in_raw_y,
  input  wire  [tgc_pkg::TIME_W-1:0]         in_now_ms,
  output logic [tgc_pkg::GEST_W-1:0]         out_gesture,
  output logic [tgc_pkg::COORD_W-1:0]        out_x,
  output logic [tgc_pkg::COORD_W-1:0]        out_y
);

  localparam int CW = tgc_pkg::COORD_W;
  localparam int DW = tgc_pkg::COORD_W + 1;

  // Configuration registers
  logic                       swap_r;
  logic [tgc_pkg::CAL_W-1:0]  x_left_r, x_right_r, y_top_r, y_bottom_r;
  logic                       raw_tap_r;
  logic [tgc_pkg::THR_W-1:0]  thr_r;
  logic [tgc_pkg::LP_W-1:0]   long_ms_r;

  // Captured request
  logic [tgc_pkg::CNT_IN_W-1:0] cnt_r;
  logic [tgc_pkg::RAW_W-1:0]    rx_r, ry_r;
  logic [tgc_pkg::TIME_W-1:0]   now_r;

  // Touch state
  logic                       finger_down_r, finger_down_nxt;
  logic                       lp_sent_r, lp_sent_nxt;
  logic [tgc_pkg::TIME_W-1:0] start_r, start_nxt;
  logic [CW-1:0]              down_x_r, down_x_nxt, down_y_r, down_y_nxt;
  logic [CW-1:0]              last_x_r, last_x_nxt, last_y_r, last_y_nxt;

  // Result register
  logic [tgc_pkg::GEST_W-1:0] gest_r, gest_nxt;
  logic [CW-1:0]              ox_r, ox_nxt, oy_r, oy_nxt;

  logic [tgc_pkg::RAW_W-1:0] ax, ay;
  logic [CW-1:0]             sx, sy;
  logic                      finger, new_press, lp_base, glitch_ok, still, lp_fire;
  logic [DW-1:0]             mv_x, mv_y, tr_x, tr_y, rel_dx, rel_dy;
  logic [tgc_pkg::TIME_W-1:0] held;

  function automatic logic [tgc_pkg::COORD_W:0] abs_d(input logic [tgc_pkg::COORD_W:0] v);
    abs_d = v[tgc_pkg::COORD_W] ? (tgc_pkg::COORD_W + 1)'(-v) : v;
  endfunction

  function automatic logic [tgc_pkg::COORD_W:0] sub_d(input logic [tgc_pkg::COORD_W-1:0] a,
                                                      input logic [tgc_pkg::COORD_W-1:0] b);
    sub_d = {1'b0, a} - {1'b0, b};
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_r     <= 1'b0;
      x_left_r   <= '0;
      x_right_r  <= tgc_pkg::RAW_FAR_RST;
      y_top_r    <= '0;
      y_bottom_r <= tgc_pkg::RAW_FAR_RST;
      raw_tap_r  <= 1'b0;
      thr_r      <= tgc_pkg::DRAG_THR_RST;
      long_ms_r  <= tgc_pkg::LONG_PRESS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        tgc_pkg::REG_SWAP_AXES:  swap_r     <= cfg_wdata[0];
        tgc_pkg::REG_X_LEFT:     x_left_r   <= cfg_wdata;
        tgc_pkg::REG_X_RIGHT:    x_right_r  <= cfg_wdata;
        tgc_pkg::REG_Y_TOP:      y_top_r    <= cfg_wdata;
        tgc_pkg::REG_Y_BOTTOM:   y_bottom_r <= cfg_wdata;
        tgc_pkg::REG_RAW_TAP:    raw_tap_r  <= cfg_wdata[0];
        tgc_pkg::REG_DRAG_THR:   thr_r      <= cfg_wdata[tgc_pkg::THR_W-1:0];
        tgc_pkg::REG_LONG_PRESS: long_ms_r  <= cfg_wdata[tgc_pkg::LP_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cnt_r <= in_point_count;
      rx_r  <= in_raw_x;
      ry_r  <= in_raw_y;
      now_r <= in_now_ms;
    end
  end

  assign ax = swap_r ? ry_r : rx_r;
  assign ay = swap_r ? rx_r : ry_r;

  tgc_axis #(.SIZE(SCREEN_WIDTH)) u_axis_x (
    .clk   (clk),
    .load  (cmd.load),
    .step  (cmd.step),
    .raw   (ax),
    .r0    (x_left_r),
    .r1    (x_right_r),
    .coord (sx)
  );

  tgc_axis #(.SIZE(SCREEN_HEIGHT)) u_axis_y (
    .clk   (clk),
    .load  (cmd.load),
    .step  (cmd.step),
    .raw   (ay),
    .r0    (y_top_r),
    .r1    (y_bottom_r),
    .coord (sy)
  );

  // Track the press and classify
  always_comb begin
    finger    = (cnt_r == tgc_pkg::CNT_IN_W'(1)) || (cnt_r == tgc_pkg::CNT_IN_W'(2));
    new_press = finger && !finger_down_r;

    mv_x = abs_d(sub_d(sx, last_x_r));
    mv_y = abs_d(sub_d(sy, last_y_r));
    glitch_ok = (mv_x < DW'(tgc_pkg::GLITCH_PX)) && (mv_y < DW'(tgc_pkg::GLITCH_PX));

    start_nxt  = new_press ? now_r : start_r;
    lp_base    = new_press ? 1'b0 : lp_sent_r;
    down_x_nxt = new_press ? sx : down_x_r;
    down_y_nxt = new_press ? sy : down_y_r;
    if (new_press || (finger && glitch_ok)) begin
      last_x_nxt = sx;
      last_y_nxt = sy;
    end else begin
      last_x_nxt = last_x_r;
      last_y_nxt = last_y_r;
    end

    tr_x  = abs_d(sub_d(last_x_nxt, down_x_nxt));
    tr_y  = abs_d(sub_d(last_y_nxt, down_y_nxt));
    still = (tr_x <= DW'(thr_r)) && (tr_y <= DW'(thr_r));
    held  = now_r - start_nxt;
    lp_fire = finger && !raw_tap_r && !lp_base && still &&
              (held >= tgc_pkg::TIME_W'(long_ms_r));

    finger_down_nxt = finger;
    lp_sent_nxt     = lp_fire ? 1'b1 : lp_base;

    // Release classification uses the stored press
    rel_dx = sub_d(last_x_r, down_x_r);
    rel_dy = sub_d(last_y_r, down_y_r);

    gest_nxt = tgc_pkg::GEST_NONE;
    ox_nxt   = '0;
    oy_nxt   = '0;
    if (finger) begin
      if (lp_fire) begin
        gest_nxt = tgc_pkg::GEST_LONG_PRESS;
        ox_nxt   = down_x_nxt;
        oy_nxt   = down_y_nxt;
      end
    end else if (finger_down_r && !lp_sent_r) begin
      if (raw_tap_r) begin
        gest_nxt = tgc_pkg::GEST_TAP;
        ox_nxt   = down_x_r;
        oy_nxt   = down_y_r;
      end else if ((abs_d(rel_dy) > DW'(thr_r)) && (abs_d(rel_dy) >= abs_d(rel_dx))) begin
        gest_nxt = rel_dy[DW-1] ? tgc_pkg::GEST_DRAG_UP : tgc_pkg::GEST_DRAG_DOWN;
        ox_nxt   = last_x_r;
        oy_nxt   = last_y_r;
      end else begin
        gest_nxt = tgc_pkg::GEST_TAP;
        ox_nxt   = down_x_r;
        oy_nxt   = down_y_r;
      end
    end
  end

  // Touch flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      finger_down_r <= 1'b0;
      lp_sent_r     <= 1'b0;
    end else if (cmd.commit) begin
      finger_down_r <= finger_down_nxt;
      lp_sent_r     <= lp_sent_nxt;
    end
  end

  // Press points and result payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      start_r  <= start_nxt;
      down_x_r <= down_x_nxt;
      down_y_r <= down_y_nxt;
      last_x_r <= last_x_nxt;
      last_y_r <= last_y_nxt;
      gest_r   <= gest_nxt;
      ox_r     <= ox_nxt;
      oy_r     <= oy_nxt;
    end
  end

  assign out_gesture = gest_r;
  assign out_x       = ox_r;
  assign out_y       = oy_r;

endmodule

`default_nettype wire

/* hw/rtl/tgc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module tgc_ctrl (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire            out_stall,
  output tgc_pkg::cmd_t  cmd
);

  localparam int CNT_W = $clog2(tgc_pkg::NUM_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(tgc_pkg::NUM_W - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  // Sequence one request: capture, multiply, divide, commit
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.load  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == LAST_STEP) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* hw/rtl/touch_gesture_classifier.sv */
// Each accepted request runs through the capture, multiply, divide and commit
// states; a new request is taken only once the last has committed. Both axes
// use an iterative divider in parallel, one quotient bit per cycle, 25 bits.
// The output register frees the next request while a result waits to be taken.
// Reset (rst_n, synchronous, active low) clears the controller, the touch flags
// and restores the configuration registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module touch_gesture_classifier #(
  parameter int SCREEN_WIDTH  = tgc_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = tgc_pkg::SCREEN_HEIGHT_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_wr_en,
  input  wire  [tgc_pkg::CFG_AW-1:0]         cfg_addr,
  input  wire  [tgc_pkg::CFG_DW-1:0]         cfg_wdata,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [tgc_pkg::CNT_IN_W-1:0]       in_point_count,
  input  wire  [tgc_pkg::RAW_W-1:0]          in_raw_x,
  input  wire  [tgc_pkg::RAW_W-1:0]          in_raw_y,
  input  wire  [tgc_pkg::TIME_W-1:0]         in_now_ms,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [tgc_pkg::GEST_W-1:0]         out_gesture,
  output logic [tgc_pkg::COORD_W-1:0]        out_x,
  output logic [tgc_pkg::COORD_W-1:0]        out_y
);

  tgc_pkg::cmd_t cmd;

  tgc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  tgc_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_point_count (in_point_count),
    .in_raw_x       (in_raw_x),
    .in_raw_y       (in_raw_y),
    .in_now_ms      (in_now_ms),
    .out_gesture    (out_gesture),
    .out_x          (out_x),
    .out_y          (out_y)
  );

endmodule

`default_nettype wire

/* bench/touch_gesture_classifier_test.sv */
`timescale 1ns / 1ps

module touch_gesture_classifier_test;
  import tgc_pkg::*;

  localparam int SCREEN_W     = SCREEN_WIDTH_DEF;
  localparam int SCREEN_H     = SCREEN_HEIGHT_DEF;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RAW_MAX      = (1 << RAW_W) - 1;

  typedef struct packed {
    logic [GEST_W-1:0]  gesture;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } gesture_t;

  typedef struct packed {
    logic             swap;
    logic [CAL_W-1:0] x_left;
    logic [CAL_W-1:0] x_right;
    logic [CAL_W-1:0] y_top;
    logic [CAL_W-1:0] y_bottom;
    logic             raw_tap;
    logic [THR_W-1:0] drag_thr;
    logic [LP_W-1:0]  hold_ms;
  } calib_t;

  localparam calib_t DEFAULT_CAL = {1'b0, 16'd0, RAW_FAR_RST, 16'd0, RAW_FAR_RST, 1'b0,
                                    DRAG_THR_RST, LONG_PRESS_RST};

  // DUT stimulus, known from time zero
  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                cfg_wr_en      = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr       = '0;
  logic [CFG_DW-1:0]   cfg_wdata      = '0;
  logic                in_valid       = 1'b0;
  logic [CNT_IN_W-1:0] in_point_count = '0;
  logic [RAW_W-1:0]    in_raw_x       = '0;
  logic [RAW_W-1:0]    in_raw_y       = '0;
  logic [TIME_W-1:0]   in_now_ms      = '0;
  logic                out_stall      = 1'b0;
  wire                 in_stall;
  wire                 out_valid;
  wire  [GEST_W-1:0]   out_gesture;
  wire  [COORD_W-1:0]  out_x;
  wire  [COORD_W-1:0]  out_y;

  // Predictor state: calibration copy and touch tracking
  calib_t            cal_model = DEFAULT_CAL;
  logic              finger_down = 1'b0;
  logic [TIME_W-1:0] press_start = '0;
  logic              long_press_sent = 1'b0;
  int                down_x = 0, down_y = 0, last_x = 0, last_y = 0;

  gesture_t          pending_gestures[$];
  logic [TIME_W-1:0] clock_ms = '0;
  int                items_sent = 0;
  int                fail_count = 0;
  int                cycle_count = 0;
  int                send_idle_pct = 0;
  int                stall_pct = 0;

  touch_gesture_classifier i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_point_count (in_point_count),
    .in_raw_x       (in_raw_x),
    .in_raw_y       (in_raw_y),
    .in_now_ms      (in_now_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_gesture    (out_gesture),
    .out_x          (out_x),
    .out_y          (out_y)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int magnitude(int v);
    return (v < 0) ? -v : v;
  endfunction

  // Map one raw axis to screen pixels, signed divide, clamp to the screen
  function automatic int scale_axis(logic [RAW_W-1:0] raw, logic [CAL_W-1:0] r0,
                                    logic [CAL_W-1:0] r1, int size);
    longint a, lo, hi, span, v;
    a = longint'(raw);
    lo = longint'($signed(r0));
    hi = longint'($signed(r1));
    span = hi - lo;
    if (span == 0) span = 1;
    v = ((a - lo) * longint'(size - 1)) / span;
    if (v < 0) v = 0;
    else if (v >= longint'(size)) v = longint'(size - 1);
    return int'(v);
  endfunction

  // Advance the touch tracker by one sample and return the gesture it reports
  function automatic gesture_t classify_sample(logic [CNT_IN_W-1:0] cnt,
                                               logic [RAW_W-1:0] rx, logic [RAW_W-1:0] ry,
                                               logic [TIME_W-1:0] now);
    gesture_t          g;
    logic [RAW_W-1:0]  ax, ay;
    logic [TIME_W-1:0] held;
    int                sx, sy, dx, dy, thr;
    g = '0;
    g.gesture = GEST_NONE;
    thr = int'(cal_model.drag_thr);
    if (cnt == 4'd1 || cnt == 4'd2) begin
      ax = cal_model.swap ? ry : rx;
      ay = cal_model.swap ? rx : ry;
      sx = scale_axis(ax, cal_model.x_left, cal_model.x_right, SCREEN_W);
      sy = scale_axis(ay, cal_model.y_top, cal_model.y_bottom, SCREEN_H);
      if (!finger_down) begin
        finger_down = 1'b1;
        press_start = now;
        long_press_sent = 1'b0;
        down_x = sx;
        down_y = sy;
        last_x = sx;
        last_y = sy;
      end else if (magnitude(sx - last_x) < GLITCH_PX && magnitude(sy - last_y) < GLITCH_PX) begin
        last_x = sx;
        last_y = sy;
      end
      held = now - press_start;
      if (!cal_model.raw_tap && !long_press_sent &&
          magnitude(last_x - down_x) <= thr && magnitude(last_y - down_y) <= thr &&
          held >= TIME_W'(cal_model.hold_ms)) begin
        long_press_sent = 1'b1;
        g.gesture = GEST_LONG_PRESS;
        g.x = down_x[COORD_W-1:0];
        g.y = down_y[COORD_W-1:0];
      end
    end else if (finger_down) begin
      finger_down = 1'b0;
      dy = last_y - down_y;
      dx = last_x - down_x;
      if (long_press_sent) begin
        g.gesture = GEST_NONE;
      end else if (!cal_model.raw_tap && magnitude(dy) > thr && magnitude(dy) >= magnitude(dx)) begin
        g.gesture = (dy < 0) ? GEST_DRAG_UP : GEST_DRAG_DOWN;
        g.x = last_x[COORD_W-1:0];
        g.y = last_y[COORD_W-1:0];
      end else begin
        g.gesture = GEST_TAP;
        g.x = down_x[COORD_W-1:0];
        g.y = down_y[COORD_W-1:0];
      end
    end
    return g;
  endfunction

  task automatic flag_error(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  function automatic logic [RAW_W-1:0] clamp_raw(int v);
    if (v < 0) return '0;
    if (v > RAW_MAX) return RAW_W'(RAW_MAX);
    return v[RAW_W-1:0];
  endfunction

  // Mostly short steps; now and then a jump long enough for a long press
  function automatic void advance_clock();
    if ($urandom_range(0, 4) == 0) clock_ms += $urandom_range(0, 2 * cal_model.hold_ms + 20);
    else clock_ms += $urandom_range(1, 60);
  endfunction

  // Drive one sample request, hold it until accepted, then maybe go idle
  task automatic send_sample(logic [CNT_IN_W-1:0] cnt, logic [RAW_W-1:0] rx,
                             logic [RAW_W-1:0] ry, logic [TIME_W-1:0] now);
    in_valid       <= 1'b1;
    in_point_count <= cnt;
    in_raw_x       <= rx;
    in_raw_y       <= ry;
    in_now_ms      <= now;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_gestures.push_back(classify_sample(cnt, rx, ry, now));
    items_sent++;
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
  endtask

  // Drop valid and wait until every request has its result back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_gestures.size() != 0);
    @(posedge clk);
  endtask

  // Write all registers back to back; only called while the block is idle
  task automatic apply_setting(calib_t s);
    int idx;
    for (idx = 0; idx < 8; idx++) begin
      cfg_wr_en <= 1'b1;
      cfg_addr  <= idx[CFG_AW-1:0];
      case (idx[CFG_AW-1:0])
        REG_SWAP_AXES:  cfg_wdata <= CFG_DW'(s.swap);
        REG_X_LEFT:     cfg_wdata <= s.x_left;
        REG_X_RIGHT:    cfg_wdata <= s.x_right;
        REG_Y_TOP:      cfg_wdata <= s.y_top;
        REG_Y_BOTTOM:   cfg_wdata <= s.y_bottom;
        REG_RAW_TAP:    cfg_wdata <= CFG_DW'(s.raw_tap);
        REG_DRAG_THR:   cfg_wdata <= CFG_DW'(s.drag_thr);
        REG_LONG_PRESS: cfg_wdata <= s.hold_ms;
        default:        cfg_wdata <= '0;
      endcase
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    cal_model = s;
  endtask

  // One press: touch down, a few moves with the odd glitch, then lift unless keep_down is set
  task automatic random_press(logic keep_down);
    int px, py, reach_x, reach_y, moves, offs, c;
    px = $urandom_range(0, RAW_MAX);
    py = $urandom_range(0, RAW_MAX);
    case ($urandom_range(0, 3))
      0:       reach_y = 20;
      1:       reach_y = 200;
      2:       reach_y = 700;
      default: reach_y = 1500;
    endcase
    reach_x = $urandom_range(0, 1) ? reach_y : reach_y / 8;
    moves = $urandom_range(0, 6);
    advance_clock();
    send_sample(CNT_IN_W'($urandom_range(1, 2)), RAW_W'(px), RAW_W'(py), clock_ms);
    repeat (moves) begin
      if ($urandom_range(0, 9) == 0) begin
        px = $urandom_range(0, RAW_MAX);
        py = $urandom_range(0, RAW_MAX);
      end else begin
        offs = $urandom_range(0, 2 * reach_x);
        px = int'(clamp_raw(px + offs - reach_x));
        offs = $urandom_range(0, 2 * reach_y);
        py = int'(clamp_raw(py + offs - reach_y));
      end
      advance_clock();
      send_sample(CNT_IN_W'($urandom_range(1, 2)), RAW_W'(px), RAW_W'(py), clock_ms);
    end
    if (!keep_down) begin
      c = $urandom_range(0, 13);
      advance_clock();
      send_sample((c == 0) ? 4'd0 : 4'(c + 2), RAW_W'($urandom_range(0, RAW_MAX)),
                  RAW_W'($urandom_range(0, RAW_MAX)), clock_ms);
    end
  endtask

  // Mostly well-formed presses, some raw noise and time jumps
  task automatic run_random(int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(0, 6) == 0) begin
        if ($urandom_range(0, 3) == 0) clock_ms = $urandom;
        else advance_clock();
        send_sample(CNT_IN_W'($urandom_range(0, 15)), RAW_W'($urandom_range(0, RAW_MAX)),
                    RAW_W'($urandom_range(0, RAW_MAX)), clock_ms);
      end else begin
        random_press(1'b0);
      end
    end
  endtask

  // Reset calibration: corners, taps, drags, long press, glitch, time wrap
  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct = 0;
    send_sample(4'd0, 12'd0, 12'd0, 32'd0);
    send_sample(4'd1, 12'd0, 12'd0, 32'd10);
    send_sample(4'd0, 12'd0, 12'd0, 32'd20);
    send_sample(4'd2, 12'hFFF, 12'hFFF, 32'd30);
    send_sample(4'd15, 12'hFFF, 12'hFFF, 32'd40);
    send_sample(4'd1, 12'd2000, 12'd1000, 32'd50);
    send_sample(4'd1, 12'd2000, 12'd1900, 32'd60);
    send_sample(4'd3, 12'd0, 12'd0, 32'd70);
    send_sample(4'd2, 12'd2000, 12'd3000, 32'd80);
    send_sample(4'd2, 12'd2000, 12'd2100, 32'd90);
    send_sample(4'd7, 12'd0, 12'd0, 32'd100);
    send_sample(4'd1, 12'd1000, 12'd1000, 32'd1000);
    send_sample(4'd1, 12'd1010, 12'd1000, 32'd1499);
    send_sample(4'd1, 12'd1010, 12'd1000, 32'd1500);
    send_sample(4'd1, 12'd1020, 12'd1000, 32'd1600);
    send_sample(4'd0, 12'd0, 12'd0, 32'd1700);
    send_sample(4'd1, 12'd500, 12'd500, 32'd2000);
    send_sample(4'd1, 12'd4000, 12'd4000, 32'd2010);
    send_sample(4'd9, 12'd0, 12'd0, 32'd2020);
    send_sample(4'd1, 12'd500, 12'd2000, 32'd2100);
    send_sample(4'd1, 12'd1500, 12'd2000, 32'd2110);
    send_sample(4'd4, 12'd0, 12'd0, 32'd2120);
    send_sample(4'd1, 12'd3000, 12'd3000, 32'hFFFF_FF00);
    send_sample(4'd1, 12'd3000, 12'd3000, 32'h0000_00F4);
    send_sample(4'd0, 12'd0, 12'd0, 32'h0000_0100);
    wait_for_results();
    clock_ms = 32'h0000_0200;
  endtask

  // Swapped axes, full signed span, one reversed; zero threshold and hold
  task automatic test_swapped_full_range();
    apply_setting({1'b1, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b0, 8'd0, 16'd0});
    send_idle_pct = 50;
    stall_pct = 0;
    run_random(150);
    wait_for_results();
  endtask

  // Zero calibration spans on both axes; widest threshold and hold
  task automatic test_zero_span();
    apply_setting({1'b0, 16'd2048, 16'd2048, 16'hFFFF, 16'hFFFF, 1'b0, 8'hFF, 16'hFFFF});
    send_idle_pct = 0;
    stall_pct = 50;
    run_random(150);
    wait_for_results();
  endtask

  // Raw tap mode with mirrored calibration; leave a finger down at the end
  task automatic test_raw_tap_mode();
    apply_setting({1'b1, 16'd4095, 16'd0, 16'd3000, 16'd1000, 1'b1, 8'hFF, 16'hFFFF});
    send_idle_pct = 33;
    stall_pct = 33;
    run_random(150);
    random_press(1'b1);
    wait_for_results();
  endtask

  // Bulk random presses over four idling patterns and varied calibration
  task automatic test_random_gestures();
    calib_t s;
    int     phase;
    for (phase = 0; phase < 4; phase++) begin
      s = DEFAULT_CAL;
      if (phase != 0) begin
        s.swap = 1'($urandom_range(0, 1));
        s.drag_thr = THR_W'($urandom_range(10, 80));
        s.hold_ms = LP_W'($urandom_range(50, 800));
      end
      if (phase == 1) begin
        s.x_left = 16'd300;
        s.x_right = 16'd3800;
        s.y_top = 16'd500;
        s.y_bottom = 16'd3500;
      end
      apply_setting(s);
      case (phase)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 50; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 50; end
        default: begin send_idle_pct = 33; stall_pct = 33; end
      endcase
      run_random(200);
      wait_for_results();
    end
  endtask

  // Receiver back pressure
  always @(posedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    gesture_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_gestures.size() == 0) begin
        flag_error($sformatf("unexpected result: gesture=%0d x=%0d y=%0d",
                             out_gesture, out_x, out_y));
      end else begin
        want = pending_gestures.pop_front();
        if (out_gesture !== want.gesture || out_x !== want.x || out_y !== want.y)
          flag_error($sformatf("result differs: expected gesture=%0d x=%0d y=%0d, got %0d %0d %0d",
                               want.gesture, want.x, want.y, out_gesture, out_x, out_y));
      end
    end
  end

  // Hard stop on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("touch_gesture_classifier: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_swapped_full_range();
    test_zero_span();
    test_raw_tap_mode();
    test_random_gestures();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_gestures.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_gestures.size()));
    if (fail_count == 0) begin
      $display("touch_gesture_classifier: match");
    end else begin
      $display("touch_gesture_classifier: mismatch");
    end
    $finish;
  end

endmodule
